### src/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define VTR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("vtr assertion failed");

// Check that a condition is followed by a result on the next edge
`define VTR_ASSERT_NEXT(lbl, cond, res) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
    else $error("vtr assertion failed");

`endif

### src/vtr_pkg.sv
// Package: shared constants, command and status types for the rescale block
package vtr_pkg;

  localparam int MAX_ATOMS_DEF = 64;
  localparam int VEL_WIDTH_DEF = 24;
  localparam int FRAC          = 16;
  localparam int TEMP_WIDTH    = 32;
  localparam logic [TEMP_WIDTH-1:0] TARGET_RESET = 32'd65536;
  localparam int ROOT_WIDTH    = 64;
  localparam int ROOT_STEPS    = 32;
  localparam int RATIO_WIDTH   = 48;

  function automatic int div_width(int w, int n);
    int dw;
    dw = 2 * w + 1 + $clog2(n) + $clog2(n + 1);
    return (dw > RATIO_WIDTH) ? dw : RATIO_WIDTH;
  endfunction

  typedef struct packed {
    logic       load;
    logic       sq;
    logic [1:0] comp;
    logic       dcalc;
    logic       div_start;
    logic       div_sel;
    logic       div_step;
    logic       tlatch;
    logic       sqrt_start;
    logic       sqrt_step;
    logic       rd;
    logic       mul;
    logic       emit;
    logic       clear;
  } vtr_cmd_t;

  typedef struct packed {
    logic full;
    logic zero;
  } vtr_sts_t;

endpackage

### src/vtr_if.sv
// Interfaces: input, result and configuration channels
interface vtr_in_if #(parameter int W = vtr_pkg::VEL_WIDTH_DEF);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] vel_x;
  logic signed [W-1:0] vel_y;
  logic signed [W-1:0] vel_z;
  logic                last_atom;
  modport source (output valid, vel_x, vel_y, vel_z, last_atom, input ready);
  modport sink   (input valid, vel_x, vel_y, vel_z, last_atom, output ready);
endinterface

interface vtr_out_if #(parameter int W = vtr_pkg::VEL_WIDTH_DEF);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] scaled_x;
  logic signed [W-1:0] scaled_y;
  logic signed [W-1:0] scaled_z;
  logic                final_result;
  logic                zero_temperature;
  logic                clipped;
  modport source (output valid, scaled_x, scaled_y, scaled_z, final_result,
                  zero_temperature, clipped, input ready);
  modport sink   (input valid, scaled_x, scaled_y, scaled_z, final_result,
                  zero_temperature, clipped, output ready);
endinterface

interface vtr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [vtr_pkg::TEMP_WIDTH-1:0]    data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### src/velocity_temperature_rescale.sv
// Top level: velocity rescaling thermostat over a stored set of atoms
// Loading takes one word per cycle; the last word starts a pass of two restoring divides of
// DIVW bits and a 32-step square root, or of one divide only when the temperature is zero.
// Each stored atom is then read from memory, multiplied, saturated and handed over on out_ready.
// rst_n is synchronous, active low: clears the set, sums and sets the target to 1.0.
`include "assert_macros.svh"
module velocity_temperature_rescale #(
  parameter int MAX_ATOMS = vtr_pkg::MAX_ATOMS_DEF,
  parameter int VEL_WIDTH = vtr_pkg::VEL_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  vtr_in_if.sink     in_ch,
  vtr_out_if.source  out_ch,
  vtr_cfg_if.sink    cfg_ch
);

  vtr_pkg::vtr_cmd_t             cmd;
  vtr_pkg::vtr_sts_t             sts;
  logic [$clog2(MAX_ATOMS+1)-1:0] count;
  logic [$clog2(MAX_ATOMS)-1:0]   addr;

  assign cfg_ch.ready = 1'b1;

  vtr_ctrl #(.N(MAX_ATOMS), .W(VEL_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last_atom),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .count     (count),
    .cmd       (cmd),
    .addr      (addr)
  );

  vtr_dp #(.N(MAX_ATOMS), .W(VEL_WIDTH)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .addr             (addr),
    .vel_x            (in_ch.vel_x),
    .vel_y            (in_ch.vel_y),
    .vel_z            (in_ch.vel_z),
    .cfg_we           (cfg_ch.valid),
    .cfg_data         (cfg_ch.data),
    .scaled_x         (out_ch.scaled_x),
    .scaled_y         (out_ch.scaled_y),
    .scaled_z         (out_ch.scaled_z),
    .final_result     (out_ch.final_result),
    .zero_temperature (out_ch.zero_temperature),
    .clipped          (out_ch.clipped),
    .sts              (sts),
    .count            (count)
  );

  `VTR_ASSERT(a_no_overlap, !(in_ch.ready && out_ch.valid))
  `VTR_ASSERT_NEXT(a_reload, out_ch.valid && out_ch.ready && out_ch.final_result, in_ch.ready)
  `VTR_ASSERT(a_zero_noclip, !(out_ch.valid && out_ch.zero_temperature && out_ch.clipped))

endmodule

### src/vtr_dp.sv
// Datapath: atom store, sums, divider, square root and output scaling
module vtr_dp #(
  parameter int N = vtr_pkg::MAX_ATOMS_DEF,
  parameter int W = vtr_pkg::VEL_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  vtr_pkg::vtr_cmd_t                   cmd,
  input  logic [$clog2(N)-1:0]                addr,
  input  logic signed [W-1:0]                 vel_x,
  input  logic signed [W-1:0]                 vel_y,
  input  logic signed [W-1:0]                 vel_z,
  input  logic                                cfg_we,
  input  logic [vtr_pkg::TEMP_WIDTH-1:0]      cfg_data,
  output logic signed [W-1:0]                 scaled_x,
  output logic signed [W-1:0]                 scaled_y,
  output logic signed [W-1:0]                 scaled_z,
  output logic                                final_result,
  output logic                                zero_temperature,
  output logic                                clipped,
  output vtr_pkg::vtr_sts_t                   sts,
  output logic [$clog2(N+1)-1:0]              count
);

  localparam int AW   = $clog2(N);
  localparam int CW   = $clog2(N + 1);
  localparam int SW   = W + $clog2(N);
  localparam int SQW  = 2 * W - 1 + $clog2(N);
  localparam int DW   = SQW + 2 + CW;
  localparam int DIVW = vtr_pkg::div_width(W, N);
  localparam int RW   = vtr_pkg::ROOT_WIDTH;
  localparam int PW   = W + vtr_pkg::FRAC;
  localparam int FR   = vtr_pkg::FRAC;

  logic [3*W-1:0]        mem [N];
  logic [3*W-1:0]        rd_r;
  logic [CW-1:0]         count_r;
  logic signed [SW-1:0]  sum_r [3];
  logic [SQW-1:0]        sq_r [3];
  logic signed [W-1:0]   pv_r [3];
  logic                  pend_r;
  logic [DW-1:0]         s2_r;
  logic [DW-1:0]         d_r;
  logic [DIVW-1:0]       dv_r;
  logic [DIVW-1:0]       div_d_r;
  logic [DIVW-1:0]       rem_r;
  logic [DIVW-1:0]       quo_r;
  logic [DIVW-1:0]       temp_r;
  logic                  zero_r;
  logic [vtr_pkg::TEMP_WIDTH-1:0] target_r;
  logic [RW-1:0]         sx_r;
  logic [RW-1:0]         sr_r;
  logic [RW-1:0]         sb_r;
  logic [PW-1:0]         p_r [3];
  logic signed [W-1:0]   ox_r [3];
  logic                  fin_r;
  logic                  clip_r;

  logic                  full;
  logic                  wr;
  logic signed [W-1:0]   vin [3];
  logic signed [2*W-1:0] sqp [3];
  logic signed [SW-1:0]  ssel;
  logic signed [2*SW-1:0] s2p;
  logic [SQW+1:0]        tot;
  logic [DW-1:0]         ntot;
  logic [DIVW-1:0]       dvn;
  logic [DIVW:0]         trial;
  logic [RW-1:0]         rt;
  logic signed [W-1:0]   xc [3];
  logic [W-1:0]          mg [3];
  logic [W+31:0]         prod [3];
  logic signed [W-1:0]   res [3];
  logic [2:0]            clipc;
  logic [PW-1:0]         lim;

  assign full  = (count_r == CW'(N));
  assign wr    = cmd.load && !full;
  assign vin[0] = vel_x;
  assign vin[1] = vel_y;
  assign vin[2] = vel_z;
  assign lim   = PW'(1) << (W - 1);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sqp[c]  = pv_r[c] * pv_r[c];
      xc[c]   = $signed(rd_r[(2-c)*W +: W]);
      mg[c]   = xc[c][W-1] ? W'(-xc[c]) : W'(xc[c]);
      prod[c] = (W+32)'(mg[c]) * (W+32)'(sr_r[31:0]);
      if (zero_r) begin
        res[c]   = xc[c];
        clipc[c] = 1'b0;
      end else if (xc[c][W-1]) begin
        clipc[c] = (p_r[c] > lim);
        res[c]   = clipc[c] ? $signed({1'b1, {(W-1){1'b0}}}) : $signed(W'(-p_r[c][W-1:0]));
      end else begin
        clipc[c] = (p_r[c] > lim - PW'(1));
        res[c]   = clipc[c] ? $signed({1'b0, {(W-1){1'b1}}}) : $signed(p_r[c][W-1:0]);
      end
    end
    ssel  = sum_r[cmd.comp];
    s2p   = ssel * ssel;
    tot   = (SQW+2)'(sq_r[0]) + (SQW+2)'(sq_r[1]) + (SQW+2)'(sq_r[2]);
    ntot  = DW'(count_r) * DW'(tot);
    dvn   = (DIVW'(count_r) * DIVW'(count_r) * DIVW'(3)) << FR;
    trial = {rem_r, quo_r[DIVW-1]};
    rt    = sr_r + sb_r;
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[count_r[AW-1:0]] <= {vel_x, vel_y, vel_z};
    end
    if (cmd.rd) begin
      rd_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      pend_r   <= 1'b0;
      s2_r     <= '0;
      zero_r   <= 1'b0;
      target_r <= vtr_pkg::TARGET_RESET;
      for (int c = 0; c < 3; c++) begin
        sum_r[c] <= '0;
        sq_r[c]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        target_r <= cfg_data;
      end
      pend_r <= wr;
      if (wr) begin
        count_r <= count_r + CW'(1);
        for (int c = 0; c < 3; c++) begin
          sum_r[c] <= sum_r[c] + SW'(vin[c]);
          pv_r[c]  <= vin[c];
        end
      end
      if (pend_r) begin
        for (int c = 0; c < 3; c++) begin
          sq_r[c] <= sq_r[c] + SQW'(sqp[c][2*W-2:0]);
        end
      end
      if (cmd.sq) begin
        s2_r <= s2_r + DW'(s2p[2*SW-2:0]);
      end
      if (cmd.dcalc) begin
        d_r  <= ntot - s2_r;
        dv_r <= dvn;
      end
      if (cmd.div_start) begin
        rem_r   <= '0;
        quo_r   <= cmd.div_sel ? DIVW'({target_r, {FR{1'b0}}}) : DIVW'(d_r);
        div_d_r <= cmd.div_sel ? temp_r : dv_r;
      end
      if (cmd.div_step) begin
        if (trial >= {1'b0, div_d_r}) begin
          rem_r <= DIVW'(trial - {1'b0, div_d_r});
          quo_r <= {quo_r[DIVW-2:0], 1'b1};
        end else begin
          rem_r <= trial[DIVW-1:0];
          quo_r <= {quo_r[DIVW-2:0], 1'b0};
        end
      end
      if (cmd.tlatch) begin
        temp_r <= quo_r;
        zero_r <= (quo_r == '0);
      end
      if (cmd.sqrt_start) begin
        sx_r <= {quo_r[vtr_pkg::RATIO_WIDTH-1:0], {FR{1'b0}}};
        sr_r <= '0;
        sb_r <= RW'(1) << (RW - 2);
      end
      if (cmd.sqrt_step) begin
        if (sx_r >= rt) begin
          sx_r <= sx_r - rt;
          sr_r <= (sr_r >> 1) + sb_r;
        end else begin
          sr_r <= sr_r >> 1;
        end
        sb_r <= sb_r >> 2;
      end
      if (cmd.mul) begin
        for (int c = 0; c < 3; c++) begin
          p_r[c] <= prod[c][W+31:FR];
        end
      end
      if (cmd.emit) begin
        for (int c = 0; c < 3; c++) begin
          ox_r[c] <= res[c];
        end
        fin_r  <= (CW'(addr) + CW'(1) == count_r);
        clip_r <= |clipc;
      end
      if (cmd.clear) begin
        count_r <= '0;
        s2_r    <= '0;
        for (int c = 0; c < 3; c++) begin
          sum_r[c] <= '0;
          sq_r[c]  <= '0;
        end
      end
    end
  end

  assign scaled_x         = ox_r[0];
  assign scaled_y         = ox_r[1];
  assign scaled_z         = ox_r[2];
  assign final_result     = fin_r;
  assign zero_temperature = zero_r;
  assign clipped          = clip_r;
  assign sts.full         = full;
  assign sts.zero         = zero_r;
  assign count            = count_r;

endmodule

### src/vtr_ctrl.sv
// Controller: sequences load, temperature, ratio, root and emit passes
module vtr_ctrl #(
  parameter int N = vtr_pkg::MAX_ATOMS_DEF,
  parameter int W = vtr_pkg::VEL_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_last,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  vtr_pkg::vtr_sts_t      sts,
  input  logic [$clog2(N+1)-1:0] count,
  output vtr_pkg::vtr_cmd_t      cmd,
  output logic [$clog2(N)-1:0]   addr
);

  localparam int AW   = $clog2(N);
  localparam int CW   = $clog2(N + 1);
  localparam int DIVW = vtr_pkg::div_width(W, N);
  localparam int NW   = $clog2(DIVW + 1);

  typedef enum logic [3:0] {
    ST_LOAD, ST_SQ, ST_DCALC, ST_D1S, ST_DIV1, ST_TCHK, ST_D2S, ST_DIV2,
    ST_RS, ST_ROOT, ST_RD, ST_MUL, ST_FMT, ST_OUT
  } state_t;

  state_t          state_r, state_nxt;
  logic [NW-1:0]   cnt_r, cnt_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic            last_idx;

  assign last_idx  = (CW'(idx_r) + CW'(1) == count);
  assign in_ready  = (state_r == ST_LOAD);
  assign out_valid = (state_r == ST_OUT);
  assign addr      = idx_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_LOAD: begin
        cmd.load = in_valid;
        cnt_nxt  = '0;
        idx_nxt  = '0;
        if (in_valid && in_last) begin
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.sq   = 1'b1;
        cmd.comp = cnt_r[1:0];
        cnt_nxt  = cnt_r + NW'(1);
        if (cnt_r == NW'(2)) begin
          state_nxt = ST_DCALC;
        end
      end
      ST_DCALC: begin
        cmd.dcalc = 1'b1;
        state_nxt = ST_D1S;
      end
      ST_D1S: begin
        cmd.div_start = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = ST_DIV1;
      end
      ST_DIV1: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + NW'(1);
        if (cnt_r == NW'(DIVW - 1)) begin
          state_nxt = ST_TCHK;
        end
      end
      ST_TCHK: begin
        cmd.tlatch = 1'b1;
        state_nxt  = ST_D2S;
      end
      ST_D2S: begin
        cnt_nxt = '0;
        if (sts.zero) begin
          state_nxt = ST_RD;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = 1'b1;
          state_nxt     = ST_DIV2;
        end
      end
      ST_DIV2: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + NW'(1);
        if (cnt_r == NW'(DIVW - 1)) begin
          state_nxt = ST_RS;
        end
      end
      ST_RS: begin
        cmd.sqrt_start = 1'b1;
        cnt_nxt        = '0;
        state_nxt      = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + NW'(1);
        if (cnt_r == NW'(vtr_pkg::ROOT_STEPS - 1)) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_FMT;
      end
      ST_FMT: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          if (last_idx) begin
            cmd.clear = 1'b1;
            state_nxt = ST_LOAD;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = ST_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

### tb/sv/vtr_checker.sv
// Checker for the rescale block: predicts each set's rescaled words and compares them
`timescale 1ns / 100ps
module vtr_checker (
  input  logic clk,
  input  logic rst_n,
  vtr_in_if    in_ch,
  vtr_out_if   out_ch,
  vtr_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending,
  output int   sets_seen,
  output int   clip_seen,
  output int   zero_seen
);

  localparam int VW = vtr_pkg::VEL_WIDTH_DEF;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] z;
    logic                 fin;
    logic                 zt;
    logic                 cl;
  } rescaled_t;

  rescaled_t            rescaled_q[$];
  logic signed [VW-1:0] set_x[$];
  logic signed [VW-1:0] set_y[$];
  logic signed [VW-1:0] set_z[$];
  logic [vtr_pkg::TEMP_WIDTH-1:0] target_temp;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [127:0] magnitude(logic signed [VW-1:0] v);
    longint s;
    s = v;
    return (s < 0) ? 128'(-s) : 128'(s);
  endfunction

  function automatic logic signed [VW-1:0] scale_comp(logic signed [VW-1:0] v,
                                                      logic [63:0] sc, ref logic clip);
    logic [127:0] p;
    longint r;
    p = (magnitude(v) * 128'(sc)) >> vtr_pkg::FRAC;
    if (v < 0) begin
      if (p > (128'd1 << (VW - 1))) begin
        p = 128'd1 << (VW - 1);
        clip = 1'b1;
      end
      r = -longint'(p);
    end else begin
      if (p > (128'd1 << (VW - 1)) - 1) begin
        p = (128'd1 << (VW - 1)) - 1;
        clip = 1'b1;
      end
      r = longint'(p);
    end
    return r[VW-1:0];
  endfunction

  task automatic rescale_set();
    int n;
    logic [127:0] dev;
    logic [127:0] acc;
    logic [127:0] tq;
    logic [127:0] sum_mag;
    longint       s;
    logic [63:0]  temp;
    logic [63:0]  ratio;
    logic [63:0]  sc;
    logic         zero;
    rescaled_t    r;
    logic         clip;
    n = set_x.size();
    dev = 0;
    for (int c = 0; c < 3; c++) begin
      acc = 0;
      s = 0;
      for (int i = 0; i < n; i++) begin
        logic signed [VW-1:0] v;
        v = (c == 0) ? set_x[i] : (c == 1) ? set_y[i] : set_z[i];
        s = s + longint'(v);
        acc = acc + magnitude(v) * magnitude(v) * 128'(n);
      end
      sum_mag = (s < 0) ? 128'(-s) : 128'(s);
      dev = dev + acc - sum_mag * sum_mag;
    end
    tq = dev / (128'd3 * 128'(n) * 128'(n) * 128'd65536);
    temp = (tq >> 64 != 0) ? {64{1'b1}} : tq[63:0];
    zero = (temp == 0);
    sc = 0;
    if (!zero) begin
      ratio = (64'(target_temp) << vtr_pkg::FRAC) / temp;
      sc = int_sqrt(ratio << vtr_pkg::FRAC);
    end
    for (int i = 0; i < n; i++) begin
      clip = 1'b0;
      if (zero) begin
        r.x = set_x[i];
        r.y = set_y[i];
        r.z = set_z[i];
      end else begin
        r.x = scale_comp(set_x[i], sc, clip);
        r.y = scale_comp(set_y[i], sc, clip);
        r.z = scale_comp(set_z[i], sc, clip);
      end
      r.fin = (i == n - 1);
      r.zt = zero;
      r.cl = clip;
      rescaled_q.insert(rescaled_q.size(), r);
    end
    if (zero) zero_seen++;
    set_x.delete();
    set_y.delete();
    set_z.delete();
    sets_seen++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    sets_seen = 0;
    clip_seen = 0;
    zero_seen = 0;
  end

  always @(posedge clk) begin
    rescaled_t got;
    rescaled_t want;
    if (!rst_n) begin
      target_temp = vtr_pkg::TARGET_RESET;
      set_x.delete();
      set_y.delete();
      set_z.delete();
      rescaled_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) target_temp = cfg_ch.data;
      if (in_ch.valid && in_ch.ready) begin
        if (set_x.size() < vtr_pkg::MAX_ATOMS_DEF) begin
          set_x.insert(set_x.size(), in_ch.vel_x);
          set_y.insert(set_y.size(), in_ch.vel_y);
          set_z.insert(set_z.size(), in_ch.vel_z);
        end
        if (in_ch.last_atom) rescale_set();
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.scaled_x, out_ch.scaled_y, out_ch.scaled_z,
                out_ch.final_result, out_ch.zero_temperature, out_ch.clipped};
        if (got.cl) clip_seen++;
        if (rescaled_q.size() == 0) begin
          $display("%0t: unexpected word %h", $time, got);
          fail_count++;
        end else begin
          want = rescaled_q.pop_front();
          if (got !== want) begin
            $display("%0t: word mismatch, expected x=%h y=%h z=%h f=%b z0=%b c=%b",
                     $time, want.x, want.y, want.z, want.fin, want.zt, want.cl);
            $display("%0t:                  actual x=%h y=%h z=%h f=%b z0=%b c=%b",
                     $time, got.x, got.y, got.z, got.fin, got.zt, got.cl);
            fail_count++;
          end
        end
      end
    end
    pending <= rescaled_q.size();
  end
endmodule

### tb/sv/tb_top.sv
// Testbench top: drives atom sets, configuration and back-pressure around the rescale block
`timescale 1ns / 100ps
module tb_top;

  localparam int VW       = vtr_pkg::VEL_WIDTH_DEF;
  localparam int LIMIT    = 2000000;
  localparam int N_RANDOM = 24;

  typedef enum int {VEL_FULL, VEL_TINY, VEL_SAME, VEL_MID} vel_mode_t;

  logic clk;
  logic rst_n;
  int   in_idle;
  int   out_idle;
  int   cycles;
  int   items;
  int   fail_count;
  int   pending;
  int   sets_seen;
  int   clip_seen;
  int   zero_seen;
  int   hold;
  bit   held;

  vtr_in_if  #(VW) in_ch ();
  vtr_out_if #(VW) out_ch ();
  vtr_cfg_if       cfg_ch ();

  velocity_temperature_rescale dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  vtr_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .sets_seen  (sets_seen),
    .clip_seen  (clip_seen),
    .zero_seen  (zero_seen)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    hold = 0;
    held = 0;
    forever begin
      @(negedge clk);
      if (!held && sets_seen >= 6 && out_ch.valid) begin
        hold = 400;
        held = 1;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = ($urandom_range(99) >= out_idle);
      end
    end
  end

  task automatic send_atom(logic signed [VW-1:0] x, y, z, logic last);
    while ($urandom_range(99) < in_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.vel_x = x;
    in_ch.vel_y = y;
    in_ch.vel_z = z;
    in_ch.last_atom = last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    items++;
  endtask

  function automatic logic signed [VW-1:0] pick_vel(vel_mode_t m, logic signed [VW-1:0] base);
    case (m)
      VEL_FULL: return VW'($urandom);
      VEL_TINY: return VW'(int'($urandom_range(0, 4095)) - 2048);
      VEL_SAME: return base;
      default:  return VW'(int'($urandom_range(0, 2097151)) - 1048576);
    endcase
  endfunction

  task automatic send_set(int n, vel_mode_t m);
    logic signed [VW-1:0] bx, by, bz;
    bx = VW'($urandom);
    by = VW'($urandom);
    bz = VW'($urandom);
    for (int i = 0; i < n; i++)
      send_atom(pick_vel(m, bx), pick_vel(m, by), pick_vel(m, bz), i == n - 1);
  endtask

  task automatic write_target(logic [vtr_pkg::TEMP_WIDTH-1:0] t);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.data = t;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic random_sets(int count);
    int stop;
    stop = items + count;
    while (items < stop)
      send_set(($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6),
               vel_mode_t'($urandom_range(3)));
  endtask

  initial begin
    cycles = 0;
    items = 0;
    in_idle = 31;
    out_idle = 55;
    in_ch.valid = 1'b0;
    in_ch.vel_x = '0;
    in_ch.vel_y = '0;
    in_ch.vel_z = '0;
    in_ch.last_atom = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_atom(24'h7FFFFF, 24'h800000, 24'h000000, 1'b0);
    send_atom(24'h800000, 24'h7FFFFF, 24'hFFFFFF, 1'b1);
    send_atom(24'h123456, 24'h800000, 24'h7FFFFF, 1'b1);
    send_set(4, VEL_SAME);
    send_set(3, VEL_TINY);
    write_target(32'h0000_0000);
    send_set(3, VEL_MID);
    write_target(32'hFFFF_FFFF);
    send_set(3, VEL_TINY);
    send_set(3, VEL_FULL);
    write_target(32'h0000_0001);
    send_set(3, VEL_TINY);
    random_sets(N_RANDOM / 3);

    in_idle = 55;
    out_idle = 31;
    write_target($urandom);
    random_sets(N_RANDOM / 3);
    write_target(32'hFFFF_FFFF);
    send_set(vtr_pkg::MAX_ATOMS_DEF + 2, VEL_MID);

    in_idle = 0;
    out_idle = 0;
    write_target(32'h0001_0000 + $urandom_range(0, 262143));
    random_sets(N_RANDOM / 3);
    in_ch.valid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Run covered %0d atoms in %0d sets under the reset and six written targets,",
             items, sets_seen);
    $display("with %0d zero-temperature sets and %0d saturated words.", zero_seen, clip_seen);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+src
src/vtr_pkg.sv
src/vtr_if.sv
src/vtr_dp.sv
src/vtr_ctrl.sv
src/velocity_temperature_rescale.sv
tb/sv/vtr_checker.sv
tb/sv/tb_top.sv
